// ----- rtl/grayscale_erosion_window_assert.svh -----
// assertion macros for the grayscale erosion window block
// no dependencies; taken in by the top level with an include
`ifndef GRAYSCALE_EROSION_WINDOW_ASSERT_SVH
`define GRAYSCALE_EROSION_WINDOW_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GEW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define GEW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gew_pkg.sv -----
// shared types and constants for the grayscale erosion window block
// no dependencies
package gew_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_ELEMENT_DEF = 7;
    localparam int HEIGHT_LIMIT    = 1024;

    // difference pixel minus element spans -32767..33023
    localparam int DIFF_W = 18;
    localparam logic signed [DIFF_W-1:0] DIFF_MAX = {1'b0, {(DIFF_W-1){1'b1}}};

    localparam logic [10:0] IMAGE_WIDTH_RST    = 11'd1024;
    localparam logic [10:0] IMAGE_HEIGHT_RST   = 11'd1024;
    localparam logic [2:0]  ELEMENT_WIDTH_RST  = 3'd3;
    localparam logic [2:0]  ELEMENT_HEIGHT_RST = 3'd3;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_ELEMENT_WIDTH,
        REG_ELEMENT_HEIGHT
    } gew_reg_t;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // one window term as it travels along the cell chain
    typedef struct packed {
        logic               valid;
        logic [7:0]         pixel;
        logic signed [15:0] elem;
    } gew_term_t;

endpackage

// ----- rtl/gew_if.sv -----
// item channel interfaces for the grayscale erosion window block
// depends on nothing; payload widths are fixed by the item format
interface gew_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [5:0]         element_index;
    logic signed [15:0] element_value;
    logic [7:0]         pixel_value;

    modport source (output valid, func, element_index, element_value, pixel_value,
                    input ready);
    modport sink (input valid, func, element_index, element_value, pixel_value,
                  output ready);
endinterface

interface gew_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic [7:0] out_value;
    logic       last;

    modport source (output valid, out_row, out_col, out_value, last, input ready);
    modport sink (input valid, out_row, out_col, out_value, last, output ready);
endinterface

// ----- rtl/gew_cell.sv -----
// one cell of the term chain: holds a term, passes it on, folds it into the minimum
// depends on gew_pkg
module gew_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clr,
    input  logic                              shift,
    input  gew_pkg::gew_term_t                prev,
    output gew_pkg::gew_term_t                held,
    input  logic signed [gew_pkg::DIFF_W-1:0] min_in,
    output logic signed [gew_pkg::DIFF_W-1:0] min_out
);
    import gew_pkg::*;

    gew_term_t               term_reg;
    gew_term_t               term_next;
    logic signed [DIFF_W-1:0] diff;

    always_comb
    begin
        term_next = term_reg;
        if (clr)
        begin
            term_next.valid = 1'b0;
        end
        else if (shift)
        begin
            term_next = prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg <= '0;
        end
        else
        begin
            term_reg <= term_next;
        end
    end

    assign diff = $signed({{(DIFF_W-8){1'b0}}, term_reg.pixel})
                - {{(DIFF_W-16){term_reg.elem[15]}}, term_reg.elem};
    assign min_out = (term_reg.valid && (diff < min_in)) ? diff : min_in;
    assign held = term_reg;
endmodule

// ----- rtl/gew_chain.sv -----
// row of term cells with a ripple minimum across them
// depends on gew_pkg and gew_cell
module gew_chain #(
    parameter int MAX_ELEMENT = gew_pkg::MAX_ELEMENT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clr,
    input  logic                              shift,
    input  gew_pkg::gew_term_t                term,
    output logic signed [gew_pkg::DIFF_W-1:0] chain_min
);
    import gew_pkg::*;

    gew_term_t                held [MAX_ELEMENT+1];
    logic signed [DIFF_W-1:0] mins [MAX_ELEMENT+1];

    assign held[0] = term;
    assign mins[0] = DIFF_MAX;

    for (genvar k = 0; k < MAX_ELEMENT; k++)
    begin : g_cell
        gew_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clr     (clr),
            .shift   (shift),
            .prev    (held[k]),
            .held    (held[k+1]),
            .min_in  (mins[k]),
            .min_out (mins[k+1])
        );
    end

    assign chain_min = mins[MAX_ELEMENT];
endmodule

// ----- rtl/grayscale_erosion_window.sv -----
// top level of the grayscale erosion window block: registers, line stores, sequencer
// depends on gew_pkg, gew_if, gew_chain, gew_cell and the assertion header
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+----------------------------------------------
//  items    | in  | valid / ready      | func, element_index, element_value, pixel_value
//  results  | out | valid / ready      | out_row, out_col, out_value, last
//  apb      | in  | psel/penable/pready| paddr, pwdata, prdata
//
// for each result of a pixel item the sequencer steps through the element rows: an
// in-frame element row runs the row, term issue (one term per element column), drain and
// accumulate steps, an out-of-frame element row takes only the row step, and one
// emit step follows; the single read port of the line store and element table
// feeds the cell chain one term a cycle
// items are taken only while the sequencer is idle; a pending result may still wait
// a stalled result holds the sequencer in its emit step until taken
// reset clears counters, registers and control; stores are undefined until written
module grayscale_erosion_window #(
    parameter int MAX_WIDTH   = gew_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ELEMENT = gew_pkg::MAX_ELEMENT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    gew_in_if.sink      items,
    gew_out_if.source   results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gew_pkg::*;

`include "grayscale_erosion_window_assert.svh"

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int SW     = ((XW > 10) ? XW : 10) + 2;
    localparam int EBW    = $clog2(MAX_ELEMENT + 1);
    localparam int SLW    = (MAX_ELEMENT > 1) ? $clog2(MAX_ELEMENT) : 1;
    localparam int TDEPTH = MAX_ELEMENT * MAX_ELEMENT;
    localparam int TW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int LDEPTH = MAX_ELEMENT * (2 ** XW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_TERM,
        S_DRAIN,
        S_ACC,
        S_EMIT
    } state_t;

    // configuration registers
    logic [10:0] cfg_w_reg, cfg_h_reg;
    logic [2:0]  cfg_ew_reg, cfg_eh_reg;
    logic        cfg_wr;
    gew_reg_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = gew_reg_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_IMAGE_WIDTH:    prdata = {21'd0, cfg_w_reg};
            REG_IMAGE_HEIGHT:   prdata = {21'd0, cfg_h_reg};
            REG_ELEMENT_WIDTH:  prdata = {29'd0, cfg_ew_reg};
            REG_ELEMENT_HEIGHT: prdata = {29'd0, cfg_eh_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg  <= IMAGE_WIDTH_RST;
            cfg_h_reg  <= IMAGE_HEIGHT_RST;
            cfg_ew_reg <= ELEMENT_WIDTH_RST;
            cfg_eh_reg <= ELEMENT_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_IMAGE_WIDTH:    cfg_w_reg  <= pwdata[10:0];
                REG_IMAGE_HEIGHT:   cfg_h_reg  <= pwdata[10:0];
                REG_ELEMENT_WIDTH:  cfg_ew_reg <= pwdata[2:0];
                REG_ELEMENT_HEIGHT: cfg_eh_reg <= pwdata[2:0];
                default:            cfg_w_reg  <= cfg_w_reg;
            endcase
        end
    end

    // saturated working sizes
    logic [WW-1:0]  w_sat;
    logic [10:0]    h_sat;
    logic [EBW-1:0] ew_sat, eh_sat, ox, oy;
    logic signed [SW-1:0] w_s, h_s, ox_s, oy_s;

    always_comb
    begin
        if (cfg_w_reg == 11'd0)
            w_sat = WW'(1);
        else if (int'(cfg_w_reg) > MAX_WIDTH)
            w_sat = WW'(MAX_WIDTH);
        else
            w_sat = WW'(cfg_w_reg);

        if (cfg_h_reg == 11'd0)
            h_sat = 11'd1;
        else if (int'(cfg_h_reg) > HEIGHT_LIMIT)
            h_sat = 11'(HEIGHT_LIMIT);
        else
            h_sat = cfg_h_reg;

        if (cfg_ew_reg == 3'd0)
            ew_sat = EBW'(1);
        else if (int'(cfg_ew_reg) > MAX_ELEMENT)
            ew_sat = EBW'(MAX_ELEMENT);
        else
            ew_sat = EBW'(cfg_ew_reg);

        if (cfg_eh_reg == 3'd0)
            eh_sat = EBW'(1);
        else if (int'(cfg_eh_reg) > MAX_ELEMENT)
            eh_sat = EBW'(MAX_ELEMENT);
        else
            eh_sat = EBW'(cfg_eh_reg);
    end

    // origin offset is (size - 1) / 2
    assign ox   = (ew_sat - EBW'(1)) >> 1;
    assign oy   = (eh_sat - EBW'(1)) >> 1;
    assign w_s  = $signed(SW'(w_sat));
    assign h_s  = $signed(SW'(h_sat));
    assign ox_s = $signed(SW'(ox));
    assign oy_s = $signed(SW'(oy));

    // sequencer registers
    state_t             state_reg, state_next;
    logic [XW-1:0]      col_cnt_reg, col_cnt_next;
    logic [9:0]         row_cnt_reg, row_cnt_next;
    logic [SLW-1:0]     slot_reg, slot_next;
    logic [SLW-1:0]     slot_cur_reg, slot_cur_next;
    logic [SLW-1:0]     yslot_reg, yslot_next;
    logic signed [SW-1:0] rcur_reg, rcur_next;
    logic signed [SW-1:0] rhi_reg, rhi_next, clo_reg, clo_next, chi_reg, chi_next;
    logic signed [SW-1:0] r_reg, r_next, c_reg, c_next;
    logic [EBW-1:0]     j_reg, j_next, i_reg, i_next;
    logic [TW-1:0]      jb_reg, jb_next;
    logic signed [DIFF_W-1:0] best_reg, best_next;
    logic               sh_reg, sh_next, tv_reg, tv_next;
    logic               ov_reg, ov_next, olast_reg, olast_next;
    logic [9:0]         orow_reg, orow_next, ocol_reg, ocol_next;
    logic [7:0]         oval_reg, oval_next;

    // memories
    logic [7:0]         line_store [LDEPTH];
    logic signed [15:0] elem_table [TDEPTH];
    logic [7:0]         lrd_reg;
    logic signed [15:0] trd_reg;

    logic                 in_acc, pix_acc, load_acc;
    logic signed [SW-1:0] rs, cs, rlo_c, rhi_c, clo_c, chi_c;
    logic signed [SW-1:0] y, x, ydist;
    logic                 y_ok, x_ok;
    logic [SLW:0]         sdiff;
    logic [SLW-1:0]       yslot_c;
    logic [SLW+XW-1:0]    laddr;
    logic [TW-1:0]        taddr;
    logic                 chain_clr;
    gew_term_t            term_in;
    logic signed [DIFF_W-1:0] chain_min;

    assign items.ready = (state_reg == S_IDLE);
    assign in_acc   = items.valid && items.ready;
    assign pix_acc  = in_acc && (items.func == FUNC_PIXEL);
    assign load_acc = in_acc && (items.func == FUNC_LOAD);

    // output window ranges for the pixel at the current counters
    assign rs = $signed(SW'(row_cnt_reg));
    assign cs = $signed(SW'(col_cnt_reg));

    always_comb
    begin
        rlo_c = rs - oy_s;
        if (rlo_c < 0)
            rlo_c = '0;
        rhi_c = (rs == h_s - SW'(1)) ? rs : (rs - oy_s);
        clo_c = cs - ox_s;
        if (clo_c < 0)
            clo_c = '0;
        chi_c = (cs == w_s - SW'(1)) ? cs : (cs - ox_s);
    end

    // image row of element row j, and its line store slot
    assign y     = r_reg + oy_s - $signed(SW'(j_reg));
    assign y_ok  = (y >= 0) && (y < h_s);
    assign ydist = rcur_reg - y;
    assign sdiff = {1'b0, slot_cur_reg} - {1'b0, ydist[SLW-1:0]};
    assign yslot_c = sdiff[SLW] ? SLW'(sdiff + (SLW+1)'(MAX_ELEMENT)) : sdiff[SLW-1:0];

    // image column of element column i
    assign x     = c_reg + ox_s - $signed(SW'(i_reg));
    assign x_ok  = (x >= 0) && (x < w_s);
    assign laddr = {yslot_reg, x[XW-1:0]};
    assign taddr = jb_reg + TW'(i_reg);

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            line_store[{slot_reg, col_cnt_reg}] <= items.pixel_value;
        end
        lrd_reg <= line_store[laddr];
    end

    always_ff @(posedge clk)
    begin
        if (load_acc && (int'(items.element_index) < TDEPTH))
        begin
            elem_table[TW'(items.element_index)] <= items.element_value;
        end
        trd_reg <= elem_table[taddr];
    end

    assign chain_clr     = (state_reg == S_ROW) && y_ok;
    assign term_in.valid = tv_reg;
    assign term_in.pixel = lrd_reg;
    assign term_in.elem  = trd_reg;

    gew_chain #(
        .MAX_ELEMENT (MAX_ELEMENT)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (chain_clr),
        .shift     (sh_reg),
        .term      (term_in),
        .chain_min (chain_min)
    );

    always_comb
    begin
        state_next    = state_reg;
        col_cnt_next  = col_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        slot_next     = slot_reg;
        slot_cur_next = slot_cur_reg;
        yslot_next    = yslot_reg;
        rcur_next     = rcur_reg;
        rhi_next      = rhi_reg;
        clo_next      = clo_reg;
        chi_next      = chi_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        j_next        = j_reg;
        i_next        = i_reg;
        jb_next       = jb_reg;
        best_next     = best_reg;
        sh_next       = 1'b0;
        tv_next       = 1'b0;
        ov_next       = ov_reg;
        olast_next    = olast_reg;
        orow_next     = orow_reg;
        ocol_next     = ocol_reg;
        oval_next     = oval_reg;

        if (ov_reg && results.ready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pix_acc)
                begin
                    rcur_next     = rs;
                    slot_cur_next = slot_reg;
                    rhi_next      = rhi_c;
                    clo_next      = clo_c;
                    chi_next      = chi_c;
                    r_next        = rlo_c;
                    c_next        = clo_c;
                    j_next        = '0;
                    jb_next       = '0;
                    best_next     = DIFF_MAX;
                    if ((rhi_c >= 0) && (chi_c >= 0))
                        state_next = S_ROW;

                    // raster counters and line ring slot
                    if (WW'(col_cnt_reg) + WW'(1) >= w_sat)
                    begin
                        col_cnt_next = '0;
                        if (11'(row_cnt_reg) + 11'd1 >= h_sat)
                            row_cnt_next = '0;
                        else
                            row_cnt_next = row_cnt_reg + 10'd1;
                        if (int'(slot_reg) == MAX_ELEMENT - 1)
                            slot_next = '0;
                        else
                            slot_next = slot_reg + SLW'(1);
                    end
                    else
                    begin
                        col_cnt_next = col_cnt_reg + XW'(1);
                    end
                end
            end

            S_ROW:
            begin
                if (y_ok)
                begin
                    yslot_next = yslot_c;
                    i_next     = '0;
                    state_next = S_TERM;
                end
                else
                begin
                    j_next  = j_reg + EBW'(1);
                    jb_next = jb_reg + TW'(MAX_ELEMENT);
                    if (j_reg == eh_sat - EBW'(1))
                        state_next = S_EMIT;
                end
            end

            S_TERM:
            begin
                sh_next = 1'b1;
                tv_next = x_ok;
                i_next  = i_reg + EBW'(1);
                if (i_reg == ew_sat - EBW'(1))
                    state_next = S_DRAIN;
            end

            S_DRAIN:
            begin
                state_next = S_ACC;
            end

            S_ACC:
            begin
                if (chain_min < best_reg)
                    best_next = chain_min;
                j_next  = j_reg + EBW'(1);
                jb_next = jb_reg + TW'(MAX_ELEMENT);
                if (j_reg == eh_sat - EBW'(1))
                    state_next = S_EMIT;
                else
                    state_next = S_ROW;
            end

            S_EMIT:
            begin
                if (!ov_reg || results.ready)
                begin
                    ov_next    = 1'b1;
                    orow_next  = r_reg[9:0];
                    ocol_next  = c_reg[9:0];
                    olast_next = (r_reg == rhi_reg) && (c_reg == chi_reg);
                    if (best_reg < 0)
                        oval_next = 8'd0;
                    else if (best_reg > DIFF_W'(255))
                        oval_next = 8'd255;
                    else
                        oval_next = best_reg[7:0];

                    j_next    = '0;
                    jb_next   = '0;
                    best_next = DIFF_MAX;
                    if (c_reg == chi_reg)
                    begin
                        c_next = clo_reg;
                        r_next = r_reg + SW'(1);
                        state_next = (r_reg == rhi_reg) ? S_IDLE : S_ROW;
                    end
                    else
                    begin
                        c_next     = c_reg + SW'(1);
                        state_next = S_ROW;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a register write restarts the frame
        if (cfg_wr)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            slot_reg     <= '0;
            slot_cur_reg <= '0;
            yslot_reg    <= '0;
            rcur_reg     <= '0;
            rhi_reg      <= '0;
            clo_reg      <= '0;
            chi_reg      <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            j_reg        <= '0;
            i_reg        <= '0;
            jb_reg       <= '0;
            best_reg     <= DIFF_MAX;
            sh_reg       <= 1'b0;
            tv_reg       <= 1'b0;
            ov_reg       <= 1'b0;
            olast_reg    <= 1'b0;
            orow_reg     <= '0;
            ocol_reg     <= '0;
            oval_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            slot_reg     <= slot_next;
            slot_cur_reg <= slot_cur_next;
            yslot_reg    <= yslot_next;
            rcur_reg     <= rcur_next;
            rhi_reg      <= rhi_next;
            clo_reg      <= clo_next;
            chi_reg      <= chi_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            j_reg        <= j_next;
            i_reg        <= i_next;
            jb_reg       <= jb_next;
            best_reg     <= best_next;
            sh_reg       <= sh_next;
            tv_reg       <= tv_next;
            ov_reg       <= ov_next;
            olast_reg    <= olast_next;
            orow_reg     <= orow_next;
            ocol_reg     <= ocol_next;
            oval_reg     <= oval_next;
        end
    end

    assign results.valid     = ov_reg;
    assign results.out_row   = orow_reg;
    assign results.out_col   = ocol_reg;
    assign results.out_value = oval_reg;
    assign results.last      = olast_reg;

    // the column counter never leaves the frame
    `GEW_ASSERT_NOW(a_col_in_frame, clk, rst_n, 1'b1, WW'(col_cnt_reg) < w_sat,
        "column counter outside frame")
    // a window always holds its origin term, so a finished minimum is real
    `GEW_ASSERT_NOW(a_best_seen, clk, rst_n, state_reg == S_EMIT, best_reg != DIFF_MAX,
        "result emitted with no window term")
    // the chain is only fed while terms are being issued
    `GEW_ASSERT_NEXT(a_shift_from_term, clk, rst_n, state_reg != S_TERM, !sh_reg,
        "chain shifted outside term issue")
endmodule
